[design/tpq_pkg.sv]
`default_nettype none

package tpq_pkg;

    localparam int THR_RESET   = 29;
    localparam int OCC_BITS    = 6;
    localparam int STATUS_BITS = 2;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } t_func;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        t_func func;
        logic  urgent;
    } t_cmd_ctl;

endpackage

`default_nettype wire

[design/tpq_if.sv]
`default_nettype none

interface tpq_in_if #(
    parameter int KEY_BITS     = 8,
    parameter int PAYLOAD_BITS = 32
);
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [KEY_BITS-1:0]     entry_key;
    logic [PAYLOAD_BITS-1:0] entry_payload;

    modport source (output valid, output func, output entry_key, output entry_payload,
                    input ready);
    modport sink   (input valid, input func, input entry_key, input entry_payload,
                    output ready);
endinterface

interface tpq_out_if #(
    parameter int KEY_BITS     = 8,
    parameter int PAYLOAD_BITS = 32
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [KEY_BITS-1:0]     removed_key;
    logic [PAYLOAD_BITS-1:0] removed_payload;
    logic [5:0]              occupancy;

    modport source (output valid, output status, output removed_key,
                    output removed_payload, output occupancy, input ready);
    modport sink   (input valid, input status, input removed_key,
                    input removed_payload, input occupancy, output ready);
endinterface

`default_nettype wire

[design/two_class_priority_queue.sv]
// Two-class strict-priority queue of (key, payload) entries.
// Input channel i_in: func 0 pushes entry_key/entry_payload, func 1 pops the head.
// A pushed key strictly above the threshold register goes to the urgent class,
// any other key to the normal class; pops drain urgent first, FIFO within a class.
// Output channel o_out: one result per input transfer, in order: status
// (pushed, popped, pop on empty, push refused full), removed key and payload
// (zero unless popped) and occupancy after the operation.
// Threshold: i_cfg_we/i_cfg_wdata, reset value 29; the user writes it only when
// the block is idle (the block itself does not enforce this). Path: command queue,
// then the execute stage, whose ring read lands in the result; both are registered.
// Throughput: one item per cycle while the receiver takes results, set by the single
// execute stage that touches one ring head or tail per operation.
// Receiver stall: the result register holds, the execute stage stops, and the
// two-entry command queue fills before i_in.ready drops.
// Reset (synchronous, active low) empties both classes at once; no clearing pass.
`default_nettype none

module two_class_priority_queue #(
    parameter int CLASS_DEPTH  = 16,
    parameter int KEY_BITS     = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [KEY_BITS-1:0] i_cfg_wdata,
    tpq_in_if.sink             i_in,
    tpq_out_if.source          o_out
);
    import tpq_pkg::*;

    logic                    cmd_valid;
    logic                    cmd_ready;
    t_cmd_ctl                cmd_ctl;
    logic [KEY_BITS-1:0]     cmd_key;
    logic [PAYLOAD_BITS-1:0] cmd_payload;

    tpq_front #(
        .KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_func(i_in.func), .i_key(i_in.entry_key), .i_payload(i_in.entry_payload),
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready),
        .o_cmd_ctl(cmd_ctl), .o_cmd_key(cmd_key), .o_cmd_payload(cmd_payload)
    );

    tpq_back #(
        .DEPTH(CLASS_DEPTH), .KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready),
        .i_cmd_ctl(cmd_ctl), .i_cmd_key(cmd_key), .i_cmd_payload(cmd_payload),
        .o_valid(o_out.valid), .i_ready(o_out.ready),
        .o_status(o_out.status), .o_key(o_out.removed_key),
        .o_payload(o_out.removed_payload), .o_occ(o_out.occupancy)
    );

endmodule

`default_nettype wire

[design/tpq_front.sv]
`default_nettype none

module tpq_front #(
    parameter int KEY_BITS     = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [KEY_BITS-1:0]     i_cfg_wdata,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire                    i_func,
    input  wire [KEY_BITS-1:0]     i_key,
    input  wire [PAYLOAD_BITS-1:0] i_payload,
    output logic                   o_cmd_valid,
    input  wire                    i_cmd_ready,
    output tpq_pkg::t_cmd_ctl      o_cmd_ctl,
    output logic [KEY_BITS-1:0]    o_cmd_key,
    output logic [PAYLOAD_BITS-1:0] o_cmd_payload
);
    import tpq_pkg::*;

    logic [KEY_BITS-1:0]     r_thr;
    t_cmd_ctl                r_ctl [2];
    logic [KEY_BITS-1:0]     r_key [2];
    logic [PAYLOAD_BITS-1:0] r_pay [2];
    logic                    r_wr_ptr;
    logic                    r_rd_ptr;
    logic [1:0]              r_cnt;
    logic [1:0]              n_cnt;
    logic                    w_in_xfer;
    logic                    w_out_xfer;
    t_cmd_ctl                w_ctl;

    assign o_ready    = (r_cnt != 2'd2);
    assign w_in_xfer  = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_out_xfer = o_cmd_valid && i_cmd_ready;

    assign o_cmd_ctl     = r_ctl[r_rd_ptr];
    assign o_cmd_key     = r_key[r_rd_ptr];
    assign o_cmd_payload = r_pay[r_rd_ptr];

    always_comb begin
        w_ctl.func   = t_func'(i_func);
        w_ctl.urgent = (i_key > r_thr);
        n_cnt = r_cnt;
        if (w_in_xfer && !w_out_xfer) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_in_xfer && w_out_xfer) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= KEY_BITS'(THR_RESET);
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (w_in_xfer) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_out_xfer) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_ctl[r_wr_ptr] <= w_ctl;
            r_key[r_wr_ptr] <= i_key;
            r_pay[r_wr_ptr] <= i_payload;
        end
    end

endmodule

`default_nettype wire

[design/tpq_ring.sv]
`default_nettype none

module tpq_ring #(
    parameter int DEPTH        = 16,
    parameter int KEY_BITS     = 8,
    parameter int PAYLOAD_BITS = 32,
    parameter int CW           = $clog2(DEPTH + 1)
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  wire                     i_pop,
    input  wire [KEY_BITS-1:0]      i_key,
    input  wire [PAYLOAD_BITS-1:0]  i_payload,
    output logic [KEY_BITS-1:0]     o_key,
    output logic [PAYLOAD_BITS-1:0] o_payload,
    output logic [CW-1:0]           o_count,
    output logic                    o_full,
    output logic                    o_empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int EW = KEY_BITS + PAYLOAD_BITS;

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] r_rdata;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;

    assign o_count   = r_count;
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_key     = r_rdata[EW-1:PAYLOAD_BITS];
    assign o_payload = r_rdata[PAYLOAD_BITS-1:0];

    always_comb begin
        n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        n_tail = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_push) begin
            r_tail  <= n_tail;
            r_count <= r_count + 1'b1;
        end else if (i_pop) begin
            r_head  <= n_head;
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_tail] <= {i_key, i_payload};
        end
        if (i_pop) begin
            r_rdata <= mem[r_head];
        end
    end

endmodule

`default_nettype wire

[design/tpq_back.sv]
`default_nettype none

module tpq_back #(
    parameter int DEPTH        = 16,
    parameter int KEY_BITS     = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cmd_valid,
    output logic                    o_cmd_ready,
    input  wire tpq_pkg::t_cmd_ctl  i_cmd_ctl,
    input  wire [KEY_BITS-1:0]      i_cmd_key,
    input  wire [PAYLOAD_BITS-1:0]  i_cmd_payload,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic [tpq_pkg::STATUS_BITS-1:0] o_status,
    output logic [KEY_BITS-1:0]     o_key,
    output logic [PAYLOAD_BITS-1:0] o_payload,
    output logic [tpq_pkg::OCC_BITS-1:0] o_occ
);
    import tpq_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SUM_W = CW + 1;

    logic                    w_load;
    logic                    w_fire;
    logic                    w_push_u;
    logic                    w_push_n;
    logic                    w_pop_u;
    logic                    w_pop_n;
    t_status                 w_status;
    logic [SUM_W-1:0]        w_occ;
    logic [KEY_BITS-1:0]     urg_key;
    logic [KEY_BITS-1:0]     nrm_key;
    logic [PAYLOAD_BITS-1:0] urg_pay;
    logic [PAYLOAD_BITS-1:0] nrm_pay;
    logic [CW-1:0]           urg_count;
    logic [CW-1:0]           nrm_count;
    logic                    urg_full;
    logic                    urg_empty;
    logic                    nrm_full;
    logic                    nrm_empty;

    logic                    r_valid;
    t_status                 r_status;
    logic [OCC_BITS-1:0]     r_occ;
    logic                    r_sel_u;
    logic                    r_sel_n;

    tpq_ring #(
        .DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS), .CW(CW)
    ) u_urgent (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push_u), .i_pop(w_pop_u),
        .i_key(i_cmd_key), .i_payload(i_cmd_payload),
        .o_key(urg_key), .o_payload(urg_pay), .o_count(urg_count),
        .o_full(urg_full), .o_empty(urg_empty)
    );

    tpq_ring #(
        .DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS), .CW(CW)
    ) u_normal (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push_n), .i_pop(w_pop_n),
        .i_key(i_cmd_key), .i_payload(i_cmd_payload),
        .o_key(nrm_key), .o_payload(nrm_pay), .o_count(nrm_count),
        .o_full(nrm_full), .o_empty(nrm_empty)
    );

    assign w_load      = !r_valid || i_ready;
    assign o_cmd_ready = w_load;
    assign w_fire      = i_cmd_valid && w_load;

    always_comb begin
        w_push_u = 1'b0;
        w_push_n = 1'b0;
        w_pop_u  = 1'b0;
        w_pop_n  = 1'b0;
        w_status = ST_EMPTY;
        if (w_fire) begin
            unique case (i_cmd_ctl.func)
                FUNC_PUSH: begin
                    if (i_cmd_ctl.urgent ? urg_full : nrm_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_status = ST_PUSHED;
                        w_push_u = i_cmd_ctl.urgent;
                        w_push_n = !i_cmd_ctl.urgent;
                    end
                end
                FUNC_POP: begin
                    if (!urg_empty) begin
                        w_status = ST_POPPED;
                        w_pop_u  = 1'b1;
                    end else if (!nrm_empty) begin
                        w_status = ST_POPPED;
                        w_pop_n  = 1'b1;
                    end
                end
                default: w_status = ST_EMPTY;
            endcase
        end
        w_occ = SUM_W'(urg_count) + SUM_W'(nrm_count);
        if (w_push_u || w_push_n) begin
            w_occ = w_occ + 1'b1;
        end else if (w_pop_u || w_pop_n) begin
            w_occ = w_occ - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= w_status;
            r_occ    <= OCC_BITS'(w_occ);
            r_sel_u  <= w_pop_u;
            r_sel_n  <= w_pop_n;
        end
    end

    assign o_valid   = r_valid;
    assign o_status  = r_status;
    assign o_occ     = r_occ;
    assign o_key     = r_sel_u ? urg_key : (r_sel_n ? nrm_key : '0);
    assign o_payload = r_sel_u ? urg_pay : (r_sel_n ? nrm_pay : '0);

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import tpq_pkg::*;

    localparam int CLASS_DEPTH  = 16;
    localparam int KEY_BITS     = 8;
    localparam int PAYLOAD_BITS = 32;
    localparam int CLS_NORMAL   = 0;
    localparam int CLS_URGENT   = 1;
    localparam int PHASES       = 12;
    localparam int PHASE_OPS    = 140;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        t_func                   func;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_queue_op;

    typedef struct packed {
        t_status                 status;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [OCC_BITS-1:0]     occupancy;
    } t_queue_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we_q = 1'b0;
    logic [KEY_BITS-1:0] cfg_wdata_q = '0;

    logic                    in_valid_q = 1'b0;
    t_func                   in_func_q = FUNC_PUSH;
    logic [KEY_BITS-1:0]     in_key_q = '0;
    logic [PAYLOAD_BITS-1:0] in_payload_q = '0;
    logic                    out_ready_q = 1'b0;

    tpq_in_if  #(.KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) in_ch ();
    tpq_out_if #(.KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) out_ch ();

    assign in_ch.valid         = in_valid_q;
    assign in_ch.func          = in_func_q;
    assign in_ch.entry_key     = in_key_q;
    assign in_ch.entry_payload = in_payload_q;
    assign out_ch.ready        = out_ready_q;

    two_class_priority_queue #(
        .CLASS_DEPTH  (CLASS_DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we_q),
        .i_cfg_wdata (cfg_wdata_q),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // shadow of the queue state
    logic [KEY_BITS-1:0]     ring_key [2][CLASS_DEPTH];
    logic [PAYLOAD_BITS-1:0] ring_payload [2][CLASS_DEPTH];
    int                      ring_head [2] = '{0, 0};
    int                      ring_held [2] = '{0, 0};
    logic [KEY_BITS-1:0]     threshold_copy = KEY_BITS'(THR_RESET);

    t_queue_op     op_backlog[$];
    t_queue_result queue_outcomes[$];
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;
    bit            calm = 1'b0;
    int            idle_left = 0;
    int            stall_left = 0;

    function automatic t_queue_result apply_op(t_func func, logic [KEY_BITS-1:0] key,
                                               logic [PAYLOAD_BITS-1:0] payload);
        t_queue_result res;
        int cls;
        int slot;
        res = '0;
        if (func == FUNC_PUSH) begin
            cls = (key > threshold_copy) ? CLS_URGENT : CLS_NORMAL;
            if (ring_held[cls] == CLASS_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                slot = (ring_head[cls] + ring_held[cls]) % CLASS_DEPTH;
                ring_key[cls][slot]     = key;
                ring_payload[cls][slot] = payload;
                ring_held[cls]++;
                res.status = ST_PUSHED;
            end
        end else begin
            cls = (ring_held[CLS_URGENT] != 0) ? CLS_URGENT : CLS_NORMAL;
            if (ring_held[cls] == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.key     = ring_key[cls][ring_head[cls]];
                res.payload = ring_payload[cls][ring_head[cls]];
                ring_head[cls] = (ring_head[cls] + 1) % CLASS_DEPTH;
                ring_held[cls]--;
                res.status = ST_POPPED;
            end
        end
        res.occupancy = OCC_BITS'(ring_held[CLS_URGENT] + ring_held[CLS_NORMAL]);
        return res;
    endfunction

    // driver
    always @(posedge clk) begin
        t_queue_op op;
        bit busy;
        if (!rst_n) begin
            in_valid_q <= 1'b0;
        end else begin
            busy = in_valid_q;
            if (in_valid_q && in_ch.ready) begin
                queue_outcomes.push_back(apply_op(in_func_q, in_key_q, in_payload_q));
                busy = 1'b0;
            end
            if (!busy) begin
                if (idle_left > 0 && !calm) begin
                    idle_left--;
                    in_valid_q <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    idle_left = $urandom_range(1, 19) - 1;
                    in_valid_q <= 1'b0;
                end else if (op_backlog.size() != 0) begin
                    op = op_backlog.pop_front();
                    in_valid_q   <= 1'b1;
                    in_func_q    <= op.func;
                    in_key_q     <= op.key;
                    in_payload_q <= op.payload;
                end else begin
                    in_valid_q <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_queue_result want;
        if (!rst_n) begin
            out_ready_q <= 1'b0;
        end else begin
            if (out_ch.valid && out_ready_q) begin
                if (queue_outcomes.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected transfer: status %0d key %0d payload %h occ %0d",
                                 out_ch.status, out_ch.removed_key, out_ch.removed_payload,
                                 out_ch.occupancy);
                    mismatch_count++;
                end else begin
                    want = queue_outcomes.pop_front();
                    if (out_ch.status !== want.status || out_ch.removed_key !== want.key ||
                        out_ch.removed_payload !== want.payload ||
                        out_ch.occupancy !== want.occupancy) begin
                        if (mismatch_count < 10)
                            $display("mismatch: exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                                     want.status, want.key, want.payload, want.occupancy,
                                     out_ch.status, out_ch.removed_key,
                                     out_ch.removed_payload, out_ch.occupancy);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0 && !calm) begin
                stall_left--;
                out_ready_q <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                out_ready_q <= 1'b0;
            end else begin
                out_ready_q <= 1'b1;
            end
        end
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    task automatic push_op(t_func func, logic [KEY_BITS-1:0] key,
                           logic [PAYLOAD_BITS-1:0] payload);
        t_queue_op op;
        op.func    = func;
        op.key     = key;
        op.payload = payload;
        op_backlog.push_back(op);
    endtask

    // sampled at the falling edge so the driver's updates have settled
    task automatic wait_idle();
        while (op_backlog.size() != 0 || in_valid_q || queue_outcomes.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_threshold(logic [KEY_BITS-1:0] value);
        @(posedge clk);
        cfg_we_q    <= 1'b1;
        cfg_wdata_q <= value;
        @(posedge clk);
        cfg_we_q <= 1'b0;
        threshold_copy = value;
    endtask

    initial begin
        int unsigned phase;
        int unsigned n;
        int unsigned push_pct;
        logic [KEY_BITS-1:0] thr;
        logic [KEY_BITS-1:0] key;
        t_func func;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset threshold, boundary keys, field extremes, empty pops
        push_op(FUNC_POP,  8'd0,   32'h0000_0000);
        push_op(FUNC_PUSH, 8'd0,   32'h0000_0000);
        push_op(FUNC_PUSH, 8'd255, 32'hffff_ffff);
        push_op(FUNC_PUSH, 8'd29,  32'ha5a5_a5a5);
        push_op(FUNC_PUSH, 8'd30,  32'h5a5a_5a5a);
        push_op(FUNC_PUSH, 8'd1,   32'h0000_0001);
        push_op(FUNC_PUSH, 8'd128, 32'h8000_0000);
        repeat (6) push_op(FUNC_POP, 8'hff, 32'hffff_ffff);
        push_op(FUNC_POP,  8'd77,  32'h1234_5678);
        push_op(FUNC_PUSH, 8'd254, 32'h7fff_ffff);
        push_op(FUNC_POP,  8'd0,   32'h0000_0000);
        wait_idle();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: thr = 8'd0;
                1: thr = 8'd255;
                2: thr = 8'd30;
                3: thr = 8'd29;
                default: thr = KEY_BITS'($urandom_range(0, 255));
            endcase
            set_threshold(thr);
            if (phase == PHASES - 1)
                calm = 1'b1;
            case (phase % 3)
                0: push_pct = 85;
                1: push_pct = 20;
                default: push_pct = 55;
            endcase
            for (n = 0; n < PHASE_OPS; n++) begin
                func = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
                case ($urandom_range(0, 4))
                    0: key = thr;
                    1: key = thr + 8'd1;
                    2: key = 8'd0;
                    3: key = 8'hff;
                    default: key = KEY_BITS'($urandom_range(0, 255));
                endcase
                push_op(func, key, $urandom());
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
